@@ rtl/core/i2cms_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cms_pkg
// Types, command codes and phase counts shared by the I2C bit sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  localparam int BYTE_BITS = 8;
  localparam int HP_W      = 16;
  localparam int PH_W      = 5;

  localparam logic [HP_W-1:0] HALF_PERIOD_RST = 16'd5;

  typedef enum logic [2:0] {
    KIND_TICK     = 3'd0,
    KIND_START    = 3'd1,
    KIND_SEND     = 3'd2,
    KIND_WAIT_ACK = 3'd3,
    KIND_READ     = 3'd4,
    KIND_SEND_ACK = 3'd5,
    KIND_STOP     = 3'd6
  } kind_t;

  // unused kind code, ignored without advancing time
  localparam logic [2:0] KIND_NONE = 3'd7;

  typedef struct packed {
    logic [2:0]           kind;
    logic [BYTE_BITS-1:0] write_byte;
    logic                 ack_level;
    logic                 sda_in;
  } in_item_t;

  typedef struct packed {
    logic                 scl_level;
    logic                 sda_level;
    logic                 sda_driven;
    logic                 busy_res;
    logic                 done_res;
    logic [BYTE_BITS-1:0] read_data;
    logic                 slave_acked;
    logic                 rejected;
  } out_word_t;

  typedef struct packed {
    logic scl;
    logic sda;
    logic drv;
  } pins_t;

  // number of bus phases per command
  function automatic logic [PH_W-1:0] phase_total(kind_t cmd);
    logic [PH_W-1:0] n;
    n = '0;
    case (cmd)
      KIND_START:    n = PH_W'(2);
      KIND_SEND:     n = PH_W'(3 * BYTE_BITS + 1);
      KIND_WAIT_ACK: n = PH_W'(2);
      KIND_READ:     n = PH_W'(2 * BYTE_BITS + 1);
      KIND_SEND_ACK: n = PH_W'(3);
      KIND_STOP:     n = PH_W'(3);
      default:       n = '0;
    endcase
    return n;
  endfunction

endpackage

@@ rtl/core/i2cms_engine.sv @@
// ----------------------------------------------------------------------------
// i2cms_engine
// Command and phase state of the I2C bit sequencer; one item per step.
// ----------------------------------------------------------------------------
module i2cms_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [i2cms_pkg::HP_W-1:0]    cfg_wdata,
  input  logic                          step,
  input  i2cms_pkg::in_item_t           item,
  output i2cms_pkg::out_word_t          res
);

  localparam int BB = i2cms_pkg::BYTE_BITS;
  localparam int PW = i2cms_pkg::PH_W;
  localparam int HW = i2cms_pkg::HP_W;

  logic [HW-1:0]       half_period;
  i2cms_pkg::kind_t    active_command, active_command_next;
  logic [PW-1:0]       phase_index, phase_index_next;
  logic [HW-1:0]       tick_count, tick_count_next;
  logic [BB-1:0]       shift_byte, shift_byte_next;
  logic                ack_level_held, ack_level_held_next;
  i2cms_pkg::pins_t    pins, pins_next;
  logic [BB-1:0]       last_read, last_read_next;
  logic                last_ack, last_ack_next;
  logic                done, rej;

  logic [HW-1:0]       hp;
  logic [HW-1:0]       tc1;
  logic [PW-1:0]       ph_inc;
  i2cms_pkg::kind_t    kind;

  // pin levels at the start of phase ph
  function automatic i2cms_pkg::pins_t apply_phase(i2cms_pkg::kind_t cmd,
      logic [PW-1:0] ph, logic [BB-1:0] sb, logic ackh, i2cms_pkg::pins_t cur);
    i2cms_pkg::pins_t p;
    logic [PW-1:0]    pm1;
    logic [2*PW-1:0]  prod;
    logic [PW-1:0]    q;
    logic [PW-1:0]    k;
    logic [2:0]       bidx;
    p    = cur;
    pm1  = ph - PW'(1);
    // divide by three: (x * 11) >> 5 is exact for x below 32
    prod = {{PW{1'b0}}, pm1} * (2*PW)'(11);
    q    = prod[2*PW-1:PW];
    k    = pm1 - q * PW'(3);
    bidx = q[2:0];
    case (cmd)
      i2cms_pkg::KIND_START: begin
        p.drv = 1'b1;
        if (ph == '0) begin
          p.sda = 1'b1;
          p.scl = 1'b1;
        end else begin
          p.sda = 1'b0;
        end
      end
      i2cms_pkg::KIND_SEND: begin
        p.drv = 1'b1;
        if (ph == '0) begin
          p.scl = 1'b0;
          p.sda = 1'b0;
        end else if (k == '0) begin
          p.sda = sb[3'(BB-1) - bidx];
        end else if (k == PW'(1)) begin
          p.scl = 1'b1;
        end else begin
          p.scl = 1'b0;
        end
      end
      i2cms_pkg::KIND_WAIT_ACK: begin
        p.drv = 1'b0;
        p.scl = (ph == '0);
      end
      i2cms_pkg::KIND_READ: begin
        p.drv = 1'b0;
        p.scl = (ph != '0) && !pm1[0];
      end
      i2cms_pkg::KIND_SEND_ACK: begin
        p.drv = 1'b1;
        if (ph == '0) p.sda = ackh;
        else if (ph == PW'(1)) p.scl = 1'b1;
        else p.scl = 1'b0;
      end
      i2cms_pkg::KIND_STOP: begin
        p.drv = 1'b1;
        if (ph == '0) begin
          p.sda = 1'b0;
          p.scl = 1'b0;
        end else if (ph == PW'(1)) begin
          p.scl = 1'b1;
        end else begin
          p.sda = 1'b1;
        end
      end
      default: p = cur;
    endcase
    return p;
  endfunction

  assign kind   = i2cms_pkg::kind_t'(item.kind);
  assign hp     = (half_period == '0) ? HW'(1) : half_period;
  assign tc1    = tick_count + HW'(1);
  assign ph_inc = phase_index + PW'(1);

  always_comb begin
    active_command_next = active_command;
    phase_index_next    = phase_index;
    tick_count_next     = tick_count;
    shift_byte_next     = shift_byte;
    ack_level_held_next = ack_level_held;
    pins_next           = pins;
    last_read_next      = last_read;
    last_ack_next       = last_ack;
    done                = 1'b0;
    rej                 = 1'b0;
    if (kind == i2cms_pkg::KIND_TICK) begin
      if (active_command != i2cms_pkg::KIND_TICK) begin
        tick_count_next = tc1;
        if (tc1 >= hp || tc1 == '0) begin
          // end of phase: sample SDA
          if (active_command == i2cms_pkg::KIND_WAIT_ACK && phase_index == '0)
            last_ack_next = !item.sda_in;
          if (active_command == i2cms_pkg::KIND_READ && phase_index != '0 &&
              phase_index[0])
            shift_byte_next = {shift_byte[BB-2:0], item.sda_in};
          tick_count_next = '0;
          if (ph_inc >= i2cms_pkg::phase_total(active_command)) begin
            if (active_command == i2cms_pkg::KIND_READ)
              last_read_next = shift_byte_next;
            active_command_next = i2cms_pkg::KIND_TICK;
            phase_index_next    = '0;
            done                = 1'b1;
          end else begin
            phase_index_next = ph_inc;
            pins_next = apply_phase(active_command, ph_inc, shift_byte_next,
                                    ack_level_held, pins);
          end
        end
      end
    end else if (item.kind != i2cms_pkg::KIND_NONE) begin
      if (active_command != i2cms_pkg::KIND_TICK) begin
        rej = 1'b1;
      end else begin
        active_command_next = kind;
        phase_index_next    = '0;
        tick_count_next     = '0;
        if (kind == i2cms_pkg::KIND_SEND) shift_byte_next = item.write_byte;
        else if (kind == i2cms_pkg::KIND_READ) shift_byte_next = '0;
        if (kind == i2cms_pkg::KIND_SEND_ACK) ack_level_held_next = item.ack_level;
        pins_next = apply_phase(kind, '0, shift_byte_next, ack_level_held_next, pins);
      end
    end
  end

  always_comb begin
    res.scl_level   = pins_next.scl;
    res.sda_level   = pins_next.drv & pins_next.sda;
    res.sda_driven  = pins_next.drv;
    res.busy_res    = (active_command_next != i2cms_pkg::KIND_TICK);
    res.done_res    = done;
    res.read_data   = last_read_next;
    res.slave_acked = last_ack_next;
    res.rejected    = rej;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period    <= i2cms_pkg::HALF_PERIOD_RST;
      active_command <= i2cms_pkg::KIND_TICK;
      phase_index    <= '0;
      tick_count     <= '0;
      shift_byte     <= '0;
      ack_level_held <= 1'b0;
      pins           <= '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
      last_read      <= '0;
      last_ack       <= 1'b0;
    end else begin
      if (cfg_we) half_period <= cfg_wdata;
      if (step) begin
        active_command <= active_command_next;
        phase_index    <= phase_index_next;
        tick_count     <= tick_count_next;
        shift_byte     <= shift_byte_next;
        ack_level_held <= ack_level_held_next;
        pins           <= pins_next;
        last_read      <= last_read_next;
        last_ack       <= last_ack_next;
      end
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    step && res.done_res |=> active_command == i2cms_pkg::KIND_TICK)
    else $error("done without return to idle");

  a_rej_busy: assert property (@(posedge clk) disable iff (rst)
    step && res.rejected |-> active_command != i2cms_pkg::KIND_TICK && !res.done_res)
    else $error("reject while idle");

  a_idle_phase: assert property (@(posedge clk) disable iff (rst)
    active_command == i2cms_pkg::KIND_TICK |-> phase_index == '0)
    else $error("phase index left over while idle");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    active_command != i2cms_pkg::KIND_TICK |->
      phase_index < i2cms_pkg::phase_total(active_command))
    else $error("phase index past command length");

endmodule

@@ rtl/core/i2c_master_bit_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_core
// I2C master bit engine: commands start bus operations, tick words advance time.
// ----------------------------------------------------------------------------
// Data path: input register, combinational engine update, result register.
// Throughput: one word per cycle while m_tready does not hold the output; the state update for a word is combinational.
// The input register takes a new word while a result waits, if the result is taken.
// Reset (rst, synchronous): idle, SCL/SDA high and driven, half_period 5.
module i2c_master_bit_sequencer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // write_byte[7:0], ack_level[8], sda_in[9], zero[15:10]
  input  logic [2:0]  s_tuser,   // kind[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // scl_level[0], sda_level[1], sda_driven[2], busy_res[3],
                                 // done_res[4], read_data[12:5], slave_acked[13],
                                 // rejected[14], zero[15]
);

  logic                  in_valid;
  i2cms_pkg::in_item_t   in_item;
  logic                  out_free;
  logic                  step;
  i2cms_pkg::out_word_t  res;
  i2cms_pkg::out_word_t  out_word;

  assign out_free = !m_tvalid || m_tready;
  assign step     = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) in_valid <= s_tvalid;
      if (out_free) m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.kind       <= s_tuser;
      in_item.write_byte <= s_tdata[7:0];
      in_item.ack_level  <= s_tdata[8];
      in_item.sda_in     <= s_tdata[9];
    end
    if (step) out_word <= res;
  end

  i2cms_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .item      (in_item),
    .res       (res)
  );

  assign m_tdata = {1'b0, out_word.rejected, out_word.slave_acked, out_word.read_data,
                    out_word.done_res, out_word.busy_res, out_word.sda_driven,
                    out_word.sda_level, out_word.scl_level};

endmodule
